// ===== src/cdg_pkg.sv =====
// Shared types and constants of the central difference gradient unit.
// Used by every module under src; depends on nothing.
package cdg_pkg;

   // Module parameter defaults
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 8;

   // Fixed field widths
   localparam int GRAD_W     = 9;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Register reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Per-transaction position flags, decided when the pixel is taken
   typedef struct packed {
      logic emit_mid;   // a gradient for the column before this one
      logic emit_end;   // the row-closing gradient from the padding column
      logic last_col;
      logic pad_row;
   } cdg_flags_type;

   // One result transaction
   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic                     last;
      logic                     frame_end;
   } cdg_result_type;

   // Up to two results handed to the queue in one cycle
   typedef struct packed {
      logic [1:0]     count;
      cdg_result_type res0;
      cdg_result_type res1;
   } cdg_push_type;

endpackage

// ===== src/cdg_ctrl.sv =====
// Column and row counters, frame geometry and the line store clearing sweep.
// Depends on cdg_pkg.
module cdg_ctrl
   import cdg_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [WIDTH_W-1:0]            active_width,
   input  logic [HEIGHT_W-1:0]           frame_height,
   input  logic                          accept,
   output logic [$clog2(MAX_WIDTH)-1:0]  idx,
   output cdg_flags_type                 flags,
   output logic                          clearing,
   output logic [$clog2(MAX_WIDTH)-1:0]  clr_addr
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CMP_W = (WIDTH_W > AW + 1) ? WIDTH_W : AW + 1;
   localparam logic [CMP_W-1:0] MAXW_C   = CMP_W'(MAX_WIDTH);
   localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_WIDTH - 1);

   logic [AW-1:0]       col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic                clr_ff, clr_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [CMP_W-1:0]    aw_ext;
   logic [AW-1:0]       wm1;
   logic [HEIGHT_W-1:0] h_min;
   logic                last_col;
   logic                pad_row;

   // Clamp the width into 1..MAX_WIDTH, kept as width minus one
   assign aw_ext = CMP_W'(active_width);
   always_comb begin
      if (active_width == '0) begin
         wm1 = '0;
      end else if (aw_ext > MAXW_C) begin
         wm1 = LAST_IDX;
      end else begin
         wm1 = AW'(aw_ext - CMP_W'(1));
      end
   end

   // A column past the width counts as the last one
   assign idx      = (col_ff > wm1) ? wm1 : col_ff;
   assign last_col = (idx == wm1);

   // A row at or past the height is the padding row
   assign h_min   = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
   assign pad_row = (row_ff >= h_min);

   assign flags.emit_mid = (row_ff != '0) && (idx != '0);
   assign flags.emit_end = (row_ff != '0) && last_col;
   assign flags.last_col = last_col;
   assign flags.pad_row  = pad_row;

   // Advance position on every accepted transaction
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = pad_row ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_in = idx + AW'(1);
         end
      end
   end

   // Sweep the line store once after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_IDX) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign clearing = clr_ff;
   assign clr_addr = clr_addr_ff;

endmodule

// ===== src/cdg_line_mem.sv =====
// Line store: one write port, one read port with registered read data.
// Each word holds the upper and middle line pixels of one column. Uses cdg_pkg.
module cdg_line_mem
   import cdg_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_WIDTH,
   parameter int DATA_W = 2 * DEF_PIXEL_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and read; a read of the address being written returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cdg_window.sv =====
// Input register stage, 3x3 window columns and gradient arithmetic.
// Depends on cdg_pkg; reads the line store and feeds the result queue.
module cdg_window
   import cdg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [$clog2(MAX_WIDTH)-1:0]  acc_idx,
   input  cdg_flags_type                 acc_flags,
   input  logic [PIXEL_BITS-1:0]         acc_pixel,
   input  logic [2*PIXEL_BITS-1:0]       rd_data,
   input  logic [FIFO_CNT_W-1:0]         fifo_count,
   output logic                          busy,
   output logic                          wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   output logic [2*PIXEL_BITS-1:0]       wr_data,
   output cdg_push_type                  push
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PB = PIXEL_BITS;
   localparam int DW = (PB + 1 > GRAD_W) ? PB + 1 : GRAD_W;

   logic                s1_valid_ff, s1_valid_in;
   logic [AW-1:0]       s1_idx_ff;
   cdg_flags_type       s1_flags_ff;
   logic [PB-1:0]       s1_pix_ff;
   logic                fwd_hit_ff;
   logic [2*PB-1:0]     fwd_data_ff;
   logic [PB-1:0]       c1_mid_ff, c1_mid_in;
   logic [PB-1:0]       c2_top_ff, c2_top_in;
   logic [PB-1:0]       c2_mid_ff, c2_mid_in;
   logic [PB-1:0]       c2_bot_ff, c2_bot_in;
   logic [2*PB-1:0]     line;
   logic [PB-1:0]       up_pix;
   logic [PB-1:0]       mid_pix;
   logic [1:0]          n_res;
   logic                go;
   logic [DW-1:0]       dx_mid, dy_mid, dx_end, dy_end;
   cdg_result_type      res_mid, res_end;

   // Take the word just written when the previous transaction hit the same column
   assign line    = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign up_pix  = line[2*PB-1:PB];
   assign mid_pix = line[PB-1:0];

   // Advance once the queue has room for every result of this transaction
   assign n_res = {1'b0, s1_flags_ff.emit_mid} + {1'b0, s1_flags_ff.emit_end};
   assign go    = s1_valid_ff &&
                  ((fifo_count + FIFO_CNT_W'(n_res)) <= FIFO_CNT_W'(FIFO_DEPTH));
   assign busy  = s1_valid_ff && !go;

   // Gradient of the previous column, after shifting in the new column
   assign dx_mid = DW'(mid_pix) - DW'(c1_mid_ff);
   assign dy_mid = DW'(c2_bot_ff) - DW'(c2_top_ff);
   // Row-closing gradient, after shifting in the zero padding column
   assign dx_end = DW'(0) - DW'(c2_mid_ff);
   assign dy_end = DW'(s1_pix_ff) - DW'(up_pix);

   always_comb begin
      res_mid.grad_x    = $signed(dx_mid[GRAD_W-1:0]);
      res_mid.grad_y    = $signed(dy_mid[GRAD_W-1:0]);
      res_mid.last      = !s1_flags_ff.last_col;
      res_mid.frame_end = 1'b0;
      res_end.grad_x    = $signed(dx_end[GRAD_W-1:0]);
      res_end.grad_y    = $signed(dy_end[GRAD_W-1:0]);
      res_end.last      = 1'b1;
      res_end.frame_end = s1_flags_ff.pad_row;
   end

   always_comb begin
      push.count = go ? n_res : 2'd0;
      push.res0  = s1_flags_ff.emit_mid ? res_mid : res_end;
      push.res1  = res_end;
   end

   // Shift the line store: middle moves up, the new pixel becomes middle
   assign wr_en   = go;
   assign wr_addr = s1_idx_ff;
   assign wr_data = {mid_pix, s1_pix_ff};

   // Slide the window; the padding column leaves zeros on a row end
   always_comb begin
      c1_mid_in = c1_mid_ff;
      c2_top_in = c2_top_ff;
      c2_mid_in = c2_mid_ff;
      c2_bot_in = c2_bot_ff;
      if (go) begin
         if (s1_flags_ff.last_col) begin
            c1_mid_in = mid_pix;
            c2_top_in = '0;
            c2_mid_in = '0;
            c2_bot_in = '0;
         end else begin
            c1_mid_in = c2_mid_ff;
            c2_top_in = up_pix;
            c2_mid_in = mid_pix;
            c2_bot_in = s1_pix_ff;
         end
      end
   end

   // Hold the stage until its results are queued
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         c1_mid_ff   <= '0;
         c2_top_ff   <= '0;
         c2_mid_ff   <= '0;
         c2_bot_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         c1_mid_ff   <= c1_mid_in;
         c2_top_ff   <= c2_top_in;
         c2_mid_ff   <= c2_mid_in;
         c2_bot_ff   <= c2_bot_in;
         if (accept) begin
            fwd_hit_ff <= go && (s1_idx_ff == acc_idx);
         end
      end
   end

   // Payload of the stage
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= acc_idx;
         s1_flags_ff <= acc_flags;
         s1_pix_ff   <= acc_pixel;
         fwd_data_ff <= {mid_pix, s1_pix_ff};
      end
   end

endmodule

// ===== src/cdg_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, presents one per cycle while rsp_stall is low.
// Depends on cdg_pkg.
module cdg_rsp_fifo
   import cdg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cdg_push_type          push,
   output logic [FIFO_CNT_W-1:0] count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cdg_result_type        rsp_data
);

   cdg_result_type          entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_nxt;
   logic                    pop;

   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = entry_ff[rd_ptr_ff];
   assign pop        = rsp_valid && !rsp_stall;
   assign wr_ptr_nxt = wr_ptr_ff + FIFO_PTR_W'(1);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed results in free slots
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_nxt] <= push.res1;
      end
   end

   assign count = count_ff;

endmodule

// ===== src/image_central_difference_gradient_unit.sv =====
// Central difference gradient over a 3x3 window, one pixel per transaction.
// Top level: registers, counters, line store, window stage and result queue.
// Depends on cdg_pkg, cdg_ctrl, cdg_line_mem, cdg_window and cdg_rsp_fifo.
//
// Usage:
//   req_* carries pixels in raster order (req_func 0) followed after each frame
//   by one row of padding transactions (req_func 1). rsp_* gives grad_x (right
//   minus left) and grad_y (below minus above) per pixel, pixels outside the
//   image read as zero. A pixel's gradient leaves one row and one column after
//   the pixel arrives; rsp_last marks the final result of a transaction and
//   rsp_frame_end the final gradient of a frame.
//   csr_* writes active_width (index 0) and frame_height (index 1); csr_ready
//   is always high. Write only while the block is idle.
// Timing:
//   A transaction is registered in the input stage and held there until the
//   queue has room for all of its results; they are then queued and leave on
//   rsp_* in order. One transaction is taken per cycle while req_stall is low.
//   A row gives as many results as it has transactions, so with the receiver
//   taking every cycle the queue never fills and req_stall stays low.
// Reset and stall:
//   After reset req_stall stays high while the line store is swept to zero.
//   When rsp_stall is high the queue fills, then req_stall rises; nothing is
//   dropped.
module image_central_difference_gradient_unit
   import cdg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [PIXEL_BITS-1:0]    req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic                     rsp_last,
   output logic                     rsp_frame_end,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int LW = 2 * PIXEL_BITS;

   logic [WIDTH_W-1:0]    active_width_ff;
   logic [HEIGHT_W-1:0]   frame_height_ff;
   logic                  accept;
   logic [AW-1:0]         idx;
   cdg_flags_type         flags;
   logic                  clearing;
   logic [AW-1:0]         clr_addr;
   logic [PIXEL_BITS-1:0] acc_pixel;
   logic                  busy;
   logic                  win_wr_en;
   logic [AW-1:0]         win_wr_addr;
   logic [LW-1:0]         win_wr_data;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [LW-1:0]         mem_wr_data;
   logic [LW-1:0]         rd_data;
   cdg_push_type          push;
   logic [FIFO_CNT_W-1:0] fifo_count;
   cdg_result_type        rsp_data;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_WIDTH: active_width_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input handshake
   assign req_stall = clearing || busy;
   assign accept    = req_valid && !req_stall;

   // Padding steps and the padding row carry a zero pixel
   assign acc_pixel = (req_func || flags.pad_row) ? '0 : req_pixel;

   cdg_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .active_width (active_width_ff),
      .frame_height (frame_height_ff),
      .accept       (accept),
      .idx          (idx),
      .flags        (flags),
      .clearing     (clearing),
      .clr_addr     (clr_addr)
   );

   // The clearing sweep owns the write port until it is done
   assign mem_wr_en   = clearing || win_wr_en;
   assign mem_wr_addr = clearing ? clr_addr : win_wr_addr;
   assign mem_wr_data = clearing ? '0 : win_wr_data;

   cdg_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (LW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   cdg_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .acc_idx    (idx),
      .acc_flags  (flags),
      .acc_pixel  (acc_pixel),
      .rd_data    (rd_data),
      .fifo_count (fifo_count),
      .busy       (busy),
      .wr_en      (win_wr_en),
      .wr_addr    (win_wr_addr),
      .wr_data    (win_wr_data),
      .push       (push)
   );

   cdg_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .count     (fifo_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_grad_x    = rsp_data.grad_x;
   assign rsp_grad_y    = rsp_data.grad_y;
   assign rsp_last      = rsp_data.last;
   assign rsp_frame_end = rsp_data.frame_end;

endmodule

// ===== src/cdg_checker.sv =====
// Port-level checks of the gradient unit and the bind that attaches them.
// Depends on cdg_pkg and image_central_difference_gradient_unit.
module cdg_checker
   import cdg_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [GRAD_W-1:0] rsp_grad_x,
   input logic signed [GRAD_W-1:0] rsp_grad_y,
   input logic                     rsp_last,
   input logic                     rsp_frame_end
);

   // The line store sweep keeps the input closed right after reset
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open right after reset");

   // No result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // The frame-closing gradient is always the last of its transaction
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last)
      else $error("frame end without last");

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_grad_x) &&
      $stable(rsp_grad_y) && $stable(rsp_last) && $stable(rsp_frame_end))
      else $error("stalled result changed");

endmodule

bind image_central_difference_gradient_unit cdg_checker u_cdg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_grad_x    (rsp_grad_x),
   .rsp_grad_y    (rsp_grad_y),
   .rsp_last      (rsp_last),
   .rsp_frame_end (rsp_frame_end)
);

// ===== dv/tb.sv =====
// Self-checking testbench for image_central_difference_gradient_unit.
// Drives pixel, padding and register transactions, predicts every gradient
// internally and compares it field by field. Depends on cdg_pkg and the RTL under src.
module tb;
   import cdg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W      = DEF_MAX_WIDTH;
   localparam int RAND_ITEMS = 500;
   localparam int QUIET_TAIL = 120;

   // Input function codes
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_PAD   = 1'b1;

   // Register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   // One directed transaction; known rows carry the outcome written out by hand
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;    // register value, or pixel in the low bits
      logic                  func;
      logic                  known;
      logic [1:0]            n_res;
      cdg_result_type        tail;    // final result of the transaction
   } stim_row_type;

   localparam int DIR_ROWS = 26;
   localparam stim_row_type DIR_TAB [DIR_ROWS] = '{
      // reset geometry is 640 wide: the start of row 0 gives nothing
      '{kind: ROW_PIX, data: 13'd255, func: FUNC_PIXEL, known: 1'b1, default: '0},
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PIXEL, known: 1'b1, default: '0},
      // shrink to 3x2 while row 0 is open at column 2
      '{kind: ROW_CSR, index: CSR_ACTIVE_WIDTH, data: 13'd3, default: '0},
      '{kind: ROW_CSR, index: CSR_FRAME_HEIGHT, data: 13'd2, default: '0},
      '{kind: ROW_PIX, data: 13'd255, func: FUNC_PIXEL, known: 1'b1, default: '0},
      // row 1: 0 255 0 against row 0: 255 0 255, top border reads zero
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PIXEL, known: 1'b1, default: '0},
      '{kind: ROW_PIX, data: 13'd255, func: FUNC_PIXEL, known: 1'b1, n_res: 2'd1,
        tail: '{9'sd0, 9'sd0, 1'b1, 1'b0}, default: '0},
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PIXEL, known: 1'b1, n_res: 2'd2,
        tail: '{9'sd0, 9'sd0, 1'b1, 1'b0}, default: '0},
      // padding row: full-scale gradients of both signs
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PAD, known: 1'b1, default: '0},
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PAD, known: 1'b1, n_res: 2'd1,
        tail: '{9'sd255, -9'sd255, 1'b1, 1'b0}, default: '0},
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PAD, known: 1'b1, n_res: 2'd2,
        tail: '{-9'sd255, -9'sd255, 1'b1, 1'b1}, default: '0},
      // padding code inside image rows, pixel code inside the padding row
      '{kind: ROW_PIX, data: 13'd200, func: FUNC_PAD, default: '0},
      '{kind: ROW_PIX, data: 13'd17, func: FUNC_PIXEL, default: '0},
      '{kind: ROW_PIX, data: 13'd255, func: FUNC_PIXEL, default: '0},
      '{kind: ROW_PIX, data: 13'd1, func: FUNC_PIXEL, default: '0},
      '{kind: ROW_PIX, data: 13'd99, func: FUNC_PAD, default: '0},
      '{kind: ROW_PIX, data: 13'd254, func: FUNC_PIXEL, default: '0},
      '{kind: ROW_PIX, data: 13'd128, func: FUNC_PIXEL, default: '0},
      '{kind: ROW_PIX, data: 13'd255, func: FUNC_PAD, default: '0},
      '{kind: ROW_PIX, data: 13'd3, func: FUNC_PIXEL, default: '0},
      // writes to undecoded indexes change nothing
      '{kind: ROW_CSR, index: CSR_SPARE_B, data: 13'h1FFF, default: '0},
      '{kind: ROW_CSR, index: CSR_SPARE_A, data: 13'd0, default: '0},
      // zero width and zero height both act as one
      '{kind: ROW_CSR, index: CSR_ACTIVE_WIDTH, data: 13'd0, default: '0},
      '{kind: ROW_CSR, index: CSR_FRAME_HEIGHT, data: 13'd0, default: '0},
      '{kind: ROW_PIX, data: 13'd255, func: FUNC_PIXEL, known: 1'b1, default: '0},
      '{kind: ROW_PIX, data: 13'd0, func: FUNC_PAD, known: 1'b1, n_res: 2'd1,
        tail: '{9'sd0, 9'sd0, 1'b1, 1'b1}, default: '0}
   };

   logic clock;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_func  = FUNC_PIXEL;
   logic [DEF_PIXEL_BITS-1:0] req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [GRAD_W-1:0] rsp_grad_x;
   logic signed [GRAD_W-1:0] rsp_grad_y;
   logic                     rsp_last;
   logic                     rsp_frame_end;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ACTIVE_WIDTH;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Gradient predictor state
   logic [WIDTH_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
   logic [7:0]          upper_mem  [MAX_W];
   logic [7:0]          middle_mem [MAX_W];
   logic [7:0]          win [3][3];
   int unsigned         col_cnt;
   int unsigned         row_cnt;
   cdg_result_type      grad_q [$];

   // Run bookkeeping
   int  err_cnt  = 0;
   int  pix_cnt  = 0;
   int  grad_cnt = 0;
   int  csr_cnt  = 0;
   int  rsp_hold = 0;
   bit  idle_on  = 1'b1;
   cdg_result_type rsp_want;
   cdg_result_type rsp_got;

   image_central_difference_gradient_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_grad_x    (rsp_grad_x),
      .rsp_grad_y    (rsp_grad_y),
      .rsp_last      (rsp_last),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #20_000_000;
      $display("%0t: timeout, %0d gradients still expected", $time, grad_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void compare_field(string what, logic signed [15:0] want_v,
                                         logic signed [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
         err_cnt++;
      end
   endfunction

   function automatic void compare_result(string tag, cdg_result_type want,
                                          cdg_result_type got);
      compare_field({tag, " grad_x"}, 16'(want.grad_x), 16'(got.grad_x));
      compare_field({tag, " grad_y"}, 16'(want.grad_y), 16'(got.grad_y));
      compare_field({tag, " last"}, 16'(want.last), 16'(got.last));
      compare_field({tag, " frame_end"}, 16'(want.frame_end), 16'(got.frame_end));
   endfunction

   function automatic int unsigned eff_width();
      if (cfg_width == 0)
         return 1;
      if (cfg_width > MAX_W)
         return MAX_W;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height == 0)
         return 1;
      return 32'(cfg_height);
   endfunction

   // Slide the 3x3 window one column and load the new right column
   function automatic void shift_column(logic [7:0] top, logic [7:0] mid, logic [7:0] bot);
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
   endfunction

   // Central differences of the window's center pixel, wrapped to 9 bits
   function automatic cdg_result_type center_gradient(logic is_last, logic is_end);
      cdg_result_type r;
      r.grad_x    = {1'b0, win[1][2]} - {1'b0, win[1][0]};
      r.grad_y    = {1'b0, win[2][1]} - {1'b0, win[0][1]};
      r.last      = is_last;
      r.frame_end = is_end;
      return r;
   endfunction

   // Advance the line stores by one transaction and queue the gradients it yields
   function automatic int gradient_step(logic func, logic [7:0] pixel);
      int unsigned idx;
      logic        last_col;
      logic        pad_row;
      logic [7:0]  px;
      int          n;
      n        = 0;
      idx      = (col_cnt >= eff_width()) ? eff_width() - 1 : col_cnt;
      last_col = (idx + 1 >= eff_width());
      pad_row  = (row_cnt >= eff_height());
      px       = (func == FUNC_PAD || pad_row) ? 8'd0 : pixel;
      shift_column(upper_mem[idx], middle_mem[idx], px);
      upper_mem[idx]  = middle_mem[idx];
      middle_mem[idx] = px;
      if (row_cnt >= 1 && idx >= 1) begin
         grad_q.push_back(center_gradient(!last_col, 1'b0));
         n++;
      end
      if (last_col) begin
         // internal zero column closes the row
         shift_column(8'd0, 8'd0, 8'd0);
         if (row_cnt >= 1) begin
            grad_q.push_back(center_gradient(1'b1, pad_row));
            n++;
         end
         col_cnt = 0;
         row_cnt = pad_row ? 0 : (row_cnt + 1) & 32'h1FFF;
      end else begin
         col_cnt = idx + 1;
      end
      return n;
   endfunction

   // Present one transaction, with an optional gap first, and hold it until taken
   task automatic send_pixel(input logic func, input logic [7:0] pixel, output int n);
      int gap;
      csr_valid <= 1'b0;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_pixel <= pixel;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      n = gradient_step(func, pixel);
      pix_cnt++;
   endtask

   // Raster-order stream: padding code in the padding row, with some flipped codes
   task automatic send_stream(input int count, input int noise_pct);
      logic func;
      int   n;
      for (int i = 0; i < count; i++) begin
         func = (row_cnt >= eff_height()) ? FUNC_PAD : FUNC_PIXEL;
         if ($urandom_range(0, 99) < noise_pct)
            func = ~func;
         send_pixel(func, 8'($urandom_range(0, 255)), n);
      end
   endtask

   // Drop valid, drain all expected gradients, then cover the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (grad_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Valid stays high after the write so back-to-back writes need no extra step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      if (index == CSR_ACTIVE_WIDTH)
         cfg_width = data[WIDTH_W-1:0];
      else if (index == CSR_FRAME_HEIGHT)
         cfg_height = data[HEIGHT_W-1:0];
      csr_cnt++;
   endtask

   // Result side: check each accepted transaction and stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         rsp_got = '{rsp_grad_x, rsp_grad_y, rsp_last, rsp_frame_end};
         if (grad_q.size() == 0) begin
            $display("%0t: unexpected gradient: expected none, actual x=%0d y=%0d",
                     $time, rsp_grad_x, rsp_grad_y);
            err_cnt++;
         end else begin
            rsp_want = grad_q.pop_front();
            compare_result("gradient", rsp_want, rsp_got);
            grad_cnt++;
         end
      end
      if (rsp_hold != 0) begin
         rsp_hold--;
         if (rsp_hold == 0)
            rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_hold = $urandom_range(1, 8);
         rsp_stall <= 1'b1;
      end
   end

   initial begin
      int                    n;
      int                    frame;
      int                    rand_items;
      int                    pick;
      int                    wait_cyc;
      bit                    last_was_pix;
      logic [CSR_DATA_W-1:0] wd;
      logic [CSR_DATA_W-1:0] hd;

      // Predictor starts from cleared line stores
      for (int c = 0; c < MAX_W; c++) begin
         upper_mem[c]  = 8'd0;
         middle_mem[c] = 8'd0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = 8'd0;
      col_cnt      = 0;
      row_cnt      = 0;
      last_was_pix = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TAB[i].kind == ROW_CSR) begin
            if (last_was_pix)
               settle();
            write_reg(DIR_TAB[i].index, DIR_TAB[i].data);
            last_was_pix = 1'b0;
         end else begin
            send_pixel(DIR_TAB[i].func, DIR_TAB[i].data[7:0], n);
            if (DIR_TAB[i].known) begin
               compare_field("directed result count", 16'(DIR_TAB[i].n_res), 16'(n));
               if (n != 0)
                  compare_result("directed", DIR_TAB[i].tail, grad_q[$]);
            end
            last_was_pix = 1'b1;
         end
      end

      // Width data above the register range clamps to the widest row, which the
      // next width write cuts short; a tall frame is then cut by a height write
      settle();
      write_reg(CSR_ACTIVE_WIDTH, 13'h1FFF);
      write_reg(CSR_FRAME_HEIGHT, 13'd2);
      send_stream(40, 0);
      settle();
      write_reg(CSR_ACTIVE_WIDTH, 13'd3);
      write_reg(CSR_FRAME_HEIGHT, 13'd4096);
      send_stream(60, 0);

      // Random phases: new geometry, then whole or cut-off frames
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         settle();
         idle_on = (rand_items < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0:       wd = 13'd0;
            1:       wd = 13'd1;
            2:       wd = 13'd2;
            3:       wd = 13'($urandom_range(3, 12)) | (13'($urandom_range(1, 3)) << WIDTH_W);
            4:       wd = 13'($urandom_range(13, 64));
            default: wd = 13'($urandom_range(3, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       hd = 13'd0;
            1:       hd = 13'd1;
            2:       hd = 13'($urandom_range(7, 20));
            default: hd = 13'($urandom_range(2, 6));
         endcase
         // sometimes change just one register, which may cut a row or frame short
         pick = $urandom_range(0, 15);
         if (pick != 0)
            write_reg(CSR_ACTIVE_WIDTH, wd);
         if (pick != 1)
            write_reg(CSR_FRAME_HEIGHT, hd);
         if (pick == 2)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      13'($urandom_range(0, 8191)));
         frame = eff_width() * (eff_height() + 1);
         n     = $urandom_range(1, (2 * frame < 150) ? 2 * frame : 150);
         send_stream(n, 6);
         rand_items += n;
      end

      // Drain with a bound, then let the pipeline empty
      req_valid <= 1'b0;
      for (wait_cyc = 0; grad_q.size() != 0 && wait_cyc < 50000; wait_cyc++)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (grad_q.size() != 0) begin
         $display("%0t: %0d expected gradients never arrived", $time, grad_q.size());
         err_cnt++;
      end

      $display("Ran %0d pixel and padding transactions, checked %0d gradients,", pix_cnt,
               grad_cnt);
      $display("with %0d register writes across full, cut-off and extreme frames.", csr_cnt);
      if (err_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== image_central_difference_gradient_unit.f =====
src/cdg_pkg.sv
src/cdg_ctrl.sv
src/cdg_line_mem.sv
src/cdg_window.sv
src/cdg_rsp_fifo.sv
src/image_central_difference_gradient_unit.sv
src/cdg_checker.sv
dv/tb.sv
